// ===== design/u8dec_pkg.sv =====
package u8dec_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;
  localparam int unsigned REM_W = 2;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_NULL       = 3'd2,
    ST_INVALID    = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_e;

  // Meaning of a byte if it arrives with no sequence open.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    lead_e      lead;
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } cls_t;

endpackage

// ===== design/u8dec_front.sv =====
module u8dec_front import u8dec_pkg::*; (
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     q_ready_i,
  output logic     in_ready_o,
  output logic     q_push_o,
  output cls_t     q_cls_o
);

  lead_e lead;

  always_comb begin
    if (in_item_i.data_byte[7] == 1'b0) begin
      lead = LEAD_ASCII;
    end else if ((in_item_i.data_byte & 8'hE0) == 8'hC0) begin
      lead = LEAD_TWO;
    end else if ((in_item_i.data_byte & 8'hF0) == 8'hE0) begin
      lead = LEAD_THREE;
    end else if ((in_item_i.data_byte & 8'hF8) == 8'hF0) begin
      lead = LEAD_FOUR;
    end else begin
      lead = LEAD_BAD;
    end
  end

  assign in_ready_o              = q_ready_i;
  assign q_push_o                = in_valid_i && q_ready_i;
  assign q_cls_o.lead            = lead;
  assign q_cls_o.data_byte       = in_item_i.data_byte;
  assign q_cls_o.end_of_buffer   = in_item_i.end_of_buffer;

endmodule

// ===== design/u8dec_fifo.sv =====
module u8dec_fifo import u8dec_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output cls_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CntW'(Depth)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a write");

endmodule

// ===== design/u8dec_back.sv =====
module u8dec_back import u8dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cls_t      q_cls_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [REM_W-1:0] rem_q, rem_d;
  logic [CP_W-1:0]  pv_q, pv_d;
  logic [LEN_W-1:0] tot_q, tot_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, res;

  logic [CP_W-1:0]  cont_val;
  logic [REM_W-1:0] rem_dec;
  logic [7:0]       b;

  assign b       = q_cls_i.data_byte;
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign rem_dec = rem_q - 1'b1;

  always_comb begin
    case (rem_q)
      2'd3:    cont_val = pv_q | (CP_W'(b[5:0]) << 12);
      2'd2:    cont_val = pv_q | (CP_W'(b[5:0]) << 6);
      default: cont_val = pv_q | CP_W'(b[5:0]);
    endcase
  end

  always_comb begin
    rem_d          = rem_q;
    pv_d           = pv_q;
    tot_d          = tot_q;
    res.code_point = '0;
    res.seq_length = '0;
    res.status     = ST_PENDING;

    if (rem_q == '0) begin
      unique case (q_cls_i.lead)
        LEAD_ASCII: begin
          res.code_point = CP_W'(b);
          res.seq_length = LEN_W'(1);
          res.status     = (b == 8'h00) ? ST_NULL : ST_COMPLETE;
        end
        LEAD_TWO: begin
          pv_d  = CP_W'(b[4:0]) << 6;
          rem_d = REM_W'(1);
          tot_d = LEN_W'(2);
        end
        LEAD_THREE: begin
          pv_d  = CP_W'(b[3:0]) << 12;
          rem_d = REM_W'(2);
          tot_d = LEN_W'(3);
        end
        LEAD_FOUR: begin
          pv_d  = CP_W'(b[2:0]) << 18;
          rem_d = REM_W'(3);
          tot_d = LEN_W'(4);
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
      // A multi-byte lead byte that is also the last byte can never complete.
      if ((q_cls_i.lead inside {LEAD_TWO, LEAD_THREE, LEAD_FOUR}) &&
          q_cls_i.end_of_buffer) begin
        rem_d      = '0;
        pv_d       = '0;
        tot_d      = '0;
        res.status = ST_INCOMPLETE;
      end
    end else if (rem_dec == '0) begin
      res.code_point = cont_val;
      res.seq_length = tot_q;
      res.status     = ST_COMPLETE;
      rem_d          = '0;
      pv_d           = '0;
      tot_d          = '0;
    end else if (q_cls_i.end_of_buffer) begin
      res.status = ST_INCOMPLETE;
      rem_d      = '0;
      pv_d       = '0;
      tot_d      = '0;
    end else begin
      pv_d  = cont_val;
      rem_d = rem_dec;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      pv_q        <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        rem_q <= rem_d;
        pv_q  <= pv_d;
        tot_q <= tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> (pv_q == '0 && tot_q == '0))
    else $error("idle decoder holds leftover sequence state");

  a_len_above_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (tot_q > LEN_W'(rem_q)))
    else $error("sequence length not above remaining byte count");

  a_bad_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && rem_q == '0 && q_cls_i.lead == LEAD_BAD)
      |=> (out_valid_q && out_q.status == ST_INVALID))
    else $error("invalid lead byte not reported");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_COMPLETE && out_q.status != ST_NULL)
      |-> (out_q.code_point == '0 && out_q.seq_length == '0))
    else $error("non-character result carries data");

endmodule

// ===== design/utf8_stream_decoder_top.sv =====
// Path: an accepted byte is written into the queue, then popped by the back end,
// which registers its result in out_q for out_item_o and raises out_valid_o.
// Throughput: one byte per cycle unless the output stalls on out_ready_i.
// The queue between front and back holds QueueDepth classified bytes.
// Reset: rst_ni clears the queue, the sequence state and the output valid at once.
module utf8_stream_decoder_top import u8dec_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic q_push, q_ready, q_pop, q_valid;
  cls_t q_wdata, q_rdata;

  u8dec_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_ready_i  (q_ready),
    .in_ready_o (in_ready_o),
    .q_push_o   (q_push),
    .q_cls_o    (q_wdata)
  );

  u8dec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_wdata),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_rdata)
  );

  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cls_i     (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
